>>> design/um_pdu_header_parser_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PDU header parser
// Shorthands for clocked assertions that are switched off during reset.
// ----------------------------------------------------------------------------
`ifndef UM_PDU_HEADER_PARSER_TOP_ASSERT_SVH
`define UM_PDU_HEADER_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UMH_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("um_hdr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("um_hdr assertion failed");

`endif

>>> design/um_hdr_pkg.sv
// ----------------------------------------------------------------------------
// um_hdr_pkg
// Types and constants shared by the PDU header parser modules.
// ----------------------------------------------------------------------------
package um_hdr_pkg;

  localparam int unsigned MAX_LI_DEF = 16;

  localparam int unsigned LEN_W = 11;
  localparam int unsigned SEQ_W = 10;
  localparam int unsigned IDX_W = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SN_LOW,
    PH_LI_HI,
    PH_LI_MID,
    PH_LI_LOW,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_LI,
    KIND_PAYLOAD
  } item_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       pdu_start;
  } in_item_t;

  typedef struct packed {
    item_kind_e       kind;
    logic [1:0]       framing;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] lval;
    logic [IDX_W-1:0] lidx;
    logic [7:0]       pbyte;
    logic             last;
    logic             ovf;
  } result_t;

endpackage

>>> design/um_hdr_in_reg.sv
// ----------------------------------------------------------------------------
// um_hdr_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module um_hdr_in_reg
  import um_hdr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // The register may refill in the same cycle that the parser drains it.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> design/um_hdr_core.sv
// ----------------------------------------------------------------------------
// um_hdr_core
// Header parse state and the per-byte decode that forms one result.
// ----------------------------------------------------------------------------
module um_hdr_core
  import um_hdr_pkg::*;
#(
  parameter int unsigned MaxLi = MAX_LI_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     fire_i,
  input  in_item_t item_i,
  output logic     emit_o,
  output result_t  result_o
);

  localparam int unsigned LcW  = $clog2(MaxLi + 1);
  localparam int unsigned IdxW = (LcW > IDX_W) ? LcW : IDX_W;
  localparam logic [LcW-1:0] MaxLiC = LcW'(MaxLi);

  logic           sn_ten_bit_q;
  phase_e         phase_q, phase_d;
  logic [1:0]     held_framing_q, held_framing_d;
  logic [1:0]     held_seq_high_q, held_seq_high_d;
  logic [7:0]     held_seq_low_q, held_seq_low_d;
  logic           held_ext_q, held_ext_d;
  logic [6:0]     partial_q, partial_d;
  logic [LcW-1:0] length_count_q, length_count_d;
  logic           overflow_q, overflow_d;

  logic [IdxW-1:0] take_pos;
  logic [LcW-1:0]  take_count;
  logic            take_ovf;
  logic [7:0]      b;
  logic            pay_emit;

  assign b = item_i.data_byte;

  // Position for a completed length indicator; the count saturates at MaxLi.
  always_comb begin
    if (length_count_q >= MaxLiC) begin
      take_pos   = IdxW'(MaxLi - 1);
      take_count = MaxLiC;
      take_ovf   = 1'b1;
    end else begin
      take_pos   = IdxW'(length_count_q);
      take_count = length_count_q + LcW'(1);
      take_ovf   = overflow_q;
    end
  end

  always_comb begin
    phase_d         = phase_q;
    held_framing_d  = held_framing_q;
    held_seq_high_d = held_seq_high_q;
    held_seq_low_d  = held_seq_low_q;
    held_ext_d      = held_ext_q;
    partial_d       = partial_q;
    length_count_d  = length_count_q;
    overflow_d      = overflow_q;
    emit_o          = 1'b0;
    result_o.kind   = KIND_FIXED;
    result_o.lval   = '0;
    result_o.lidx   = '0;
    result_o.pbyte  = '0;
    result_o.last   = 1'b0;

    if (fire_i) begin
      if (item_i.pdu_start) begin
        length_count_d = '0;
        overflow_d     = 1'b0;
        partial_d      = '0;
        if (sn_ten_bit_q) begin
          // The top three bits are reserved; the fixed result waits for byte two.
          held_framing_d  = b[4:3];
          held_ext_d      = b[2];
          held_seq_high_d = b[1:0];
          held_seq_low_d  = '0;
          phase_d         = PH_SN_LOW;
        end else begin
          held_framing_d  = b[7:6];
          held_seq_high_d = '0;
          held_seq_low_d  = {3'b000, b[4:0]};
          held_ext_d      = 1'b0;
          phase_d         = b[5] ? PH_LI_HI : PH_PAYLOAD;
          emit_o          = 1'b1;
          result_o.last   = !b[5];
        end
      end else begin
        case (phase_q)
          PH_SN_LOW: begin
            held_seq_low_d = b;
            held_ext_d     = 1'b0;
            phase_d        = held_ext_q ? PH_LI_HI : PH_PAYLOAD;
            emit_o         = 1'b1;
            result_o.last  = !held_ext_q;
          end
          PH_LI_HI: begin
            held_ext_d = b[7];
            partial_d  = b[6:0];
            phase_d    = PH_LI_MID;
          end
          PH_LI_MID: begin
            length_count_d = take_count;
            overflow_d     = take_ovf;
            emit_o         = 1'b1;
            result_o.kind  = KIND_LI;
            result_o.lval  = {partial_q, b[7:4]};
            result_o.lidx  = take_pos[IDX_W-1:0];
            result_o.last  = !held_ext_q;
            if (held_ext_q) begin
              held_ext_d = b[3];
              partial_d  = {4'b0000, b[2:0]};
              phase_d    = PH_LI_LOW;
            end else begin
              // The low nibble is padding after an odd count.
              held_ext_d = 1'b0;
              phase_d    = PH_PAYLOAD;
            end
          end
          PH_LI_LOW: begin
            length_count_d = take_count;
            overflow_d     = take_ovf;
            held_ext_d     = 1'b0;
            phase_d        = held_ext_q ? PH_LI_HI : PH_PAYLOAD;
            emit_o         = 1'b1;
            result_o.kind  = KIND_LI;
            result_o.lval  = {partial_q[2:0], b};
            result_o.lidx  = take_pos[IDX_W-1:0];
            result_o.last  = !held_ext_q;
          end
          PH_PAYLOAD: begin
            emit_o         = 1'b1;
            result_o.kind  = KIND_PAYLOAD;
            result_o.pbyte = b;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end

    result_o.framing = held_framing_d;
    result_o.seq     = {held_seq_high_d, held_seq_low_d};
    result_o.ovf     = overflow_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sn_ten_bit_q    <= 1'b0;
      phase_q         <= PH_IDLE;
      held_framing_q  <= '0;
      held_seq_high_q <= '0;
      held_seq_low_q  <= '0;
      held_ext_q      <= 1'b0;
      partial_q       <= '0;
      length_count_q  <= '0;
      overflow_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sn_ten_bit_q <= cfg_wdata_i;
      end
      phase_q         <= phase_d;
      held_framing_q  <= held_framing_d;
      held_seq_high_q <= held_seq_high_d;
      held_seq_low_q  <= held_seq_low_d;
      held_ext_q      <= held_ext_d;
      partial_q       <= partial_d;
      length_count_q  <= length_count_d;
      overflow_q      <= overflow_d;
    end
  end

  assign pay_emit = emit_o && (result_o.kind == KIND_PAYLOAD);

`include "um_pdu_header_parser_top_assert.svh"

  `UMH_ASSERT_SAME(a_count_bounded, 1'b1, length_count_q <= MaxLiC)
  `UMH_ASSERT_SAME(a_ovf_saturated, overflow_q, length_count_q == MaxLiC)
  `UMH_ASSERT_SAME(a_payload_phase, pay_emit, phase_q == PH_PAYLOAD && !item_i.pdu_start)
  `UMH_ASSERT_SAME(a_last_ends_hdr, emit_o && result_o.last, phase_d == PH_PAYLOAD)

endmodule

>>> design/um_hdr_out_reg.sv
// ----------------------------------------------------------------------------
// um_hdr_out_reg
// Result register: holds one result until the receiving side takes it.
// ----------------------------------------------------------------------------
module um_hdr_out_reg
  import um_hdr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output logic    free_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // Free when empty or when the held item leaves at this edge.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

>>> design/um_pdu_header_parser_top.sv
// ----------------------------------------------------------------------------
// um_pdu_header_parser_top
// UM data PDU header parser: fixed header, length indicators, payload bytes.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake                  Payload
//   input     in          in_valid_i / in_stall_o    data_byte_i, pdu_start_i
//   result    out         out_valid_o / out_stall_i  item_kind_o .. li_overflow_o
//   config    in          cfg_we_i                   cfg_wdata_i (sn_ten_bit)
//
// One byte is accepted per cycle unless a stall holds it; it is registered, then parsed.
// The rate is set by the single parse stage between input and result registers.
// Reset clears the parse state, the configuration bit and both valid flags.
// A stall on the result side holds the result register and, once the input
// register is also full, raises in_stall_o in the same cycle.
// ----------------------------------------------------------------------------
module um_pdu_header_parser_top
  import um_hdr_pkg::*;
#(
  parameter int unsigned MaxLi = MAX_LI_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             pdu_start_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       item_kind_o,
  output logic [1:0]       framing_info_o,
  output logic [SEQ_W-1:0] seq_number_o,
  output logic [LEN_W-1:0] length_value_o,
  output logic [IDX_W-1:0] length_index_o,
  output logic [7:0]       payload_byte_o,
  output logic             header_last_o,
  output logic             li_overflow_o
);

  in_item_t in_item, stage_item;
  logic     stage_valid;
  logic     out_free;
  logic     fire;
  logic     emit;
  result_t  core_result, out_result;

  assign in_item.data_byte = data_byte_i;
  assign in_item.pdu_start = pdu_start_i;

  // A byte is parsed once the result register can take what it produces.
  assign fire = stage_valid && out_free;

  um_hdr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item),
    .take_i    (fire),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  um_hdr_core #(
    .MaxLi(MaxLi)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fire_i     (fire),
    .item_i     (stage_item),
    .emit_o     (emit),
    .result_o   (core_result)
  );

  um_hdr_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (emit),
    .result_i   (core_result),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .free_o     (out_free),
    .result_o   (out_result)
  );

  assign item_kind_o    = out_result.kind;
  assign framing_info_o = out_result.framing;
  assign seq_number_o   = out_result.seq;
  assign length_value_o = out_result.lval;
  assign length_index_o = out_result.lidx;
  assign payload_byte_o = out_result.pbyte;
  assign header_last_o  = out_result.last;
  assign li_overflow_o  = out_result.ovf;

`include "um_pdu_header_parser_top_assert.svh"

  `UMH_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  `UMH_ASSERT_SAME(a_fire_needs_item, emit, fire)
  `UMH_ASSERT_NEXT(a_emit_shows, emit, out_valid_o)

endmodule

>>> verif/um_pdu_header_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PDU header parser testbench
// Drives byte streams of well-formed, truncated and malformed UM data PDUs
// through the parser in both sequence number widths. A scoreboard tracks the
// header parse state, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module um_pdu_header_parser_top_tb;
  import um_hdr_pkg::*;

  localparam int unsigned DRAIN_PAD = 4;
  localparam int unsigned TAIL_PAD  = 8;
  localparam int unsigned HOLD_LEN  = 300;

  class hdr_scoreboard;
    bit             ten_bit = 1'b0;
    phase_e         phase = PH_IDLE;
    logic [1:0]     fi = '0;
    logic [1:0]     sn_hi = '0;
    logic [7:0]     sn_lo = '0;
    bit             ext_pend = 1'b0;
    logic [6:0]     part = '0;
    int unsigned    li_count = 0;
    bit             ovf = 1'b0;
    result_t        expected_q[$];
    int unsigned    errors = 0;
    int unsigned    inputs_noted = 0;
    int unsigned    n_fixed = 0;
    int unsigned    n_li = 0;
    int unsigned    n_ovf = 0;
    int unsigned    n_payload = 0;

    function void push_result(item_kind_e k, logic [10:0] lv, logic [3:0] li_idx,
                              logic [7:0] pb, bit hl);
      result_t r;
      r.kind    = k;
      r.framing = fi;
      r.seq     = {sn_hi, sn_lo};
      r.lval    = lv;
      r.lidx    = li_idx;
      r.pbyte   = pb;
      r.last    = hl;
      r.ovf     = ovf;
      expected_q.push_back(r);
    endfunction

    // The count saturates; a length indicator past the limit keeps the last index.
    function logic [3:0] next_li_index();
      int unsigned pos;
      pos = li_count;
      if (pos >= MAX_LI_DEF) begin
        ovf = 1'b1;
        pos = MAX_LI_DEF - 1;
        li_count = MAX_LI_DEF;
      end else begin
        li_count = pos + 1;
      end
      return pos[3:0];
    endfunction

    function void note_input(logic [7:0] b, logic s);
      bit          e;
      logic [10:0] li;
      logic [3:0]  li_idx;
      inputs_noted++;
      if (s) begin
        li_count = 0;
        ovf = 1'b0;
        part = '0;
        if (ten_bit) begin
          // Three reserved bits on top are dropped.
          fi = b[4:3];
          ext_pend = b[2];
          sn_hi = b[1:0];
          sn_lo = '0;
          phase = PH_SN_LOW;
          return;
        end
        fi = b[7:6];
        e = b[5];
        sn_hi = '0;
        sn_lo = {3'b000, b[4:0]};
        ext_pend = 1'b0;
        phase = e ? PH_LI_HI : PH_PAYLOAD;
        push_result(KIND_FIXED, '0, '0, '0, !e);
        return;
      end
      case (phase)
        PH_SN_LOW: begin
          sn_lo = b;
          e = ext_pend;
          ext_pend = 1'b0;
          phase = e ? PH_LI_HI : PH_PAYLOAD;
          push_result(KIND_FIXED, '0, '0, '0, !e);
        end
        PH_LI_HI: begin
          ext_pend = b[7];
          part = b[6:0];
          phase = PH_LI_MID;
        end
        PH_LI_MID: begin
          li = {part, b[7:4]};
          e = ext_pend;
          li_idx = next_li_index();
          if (e) begin
            ext_pend = b[3];
            part = {4'b0000, b[2:0]};
            phase = PH_LI_LOW;
          end else begin
            // The low nibble is padding after an odd count.
            ext_pend = 1'b0;
            phase = PH_PAYLOAD;
          end
          push_result(KIND_LI, li, li_idx, '0, !e);
        end
        PH_LI_LOW: begin
          li = {part[2:0], b};
          e = ext_pend;
          ext_pend = 1'b0;
          li_idx = next_li_index();
          phase = e ? PH_LI_HI : PH_PAYLOAD;
          push_result(KIND_LI, li, li_idx, '0, !e);
        end
        PH_PAYLOAD: begin
          push_result(KIND_PAYLOAD, '0, '0, b, 1'b0);
        end
        default: begin
          phase = PH_IDLE;
        end
      endcase
    endfunction

    task report_mismatch(string what, int unsigned got_v, int unsigned want_v);
      $display("MISMATCH %s: got %0d, expected %0d (after %0d input bytes)",
               what, got_v, want_v, inputs_noted);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending, item_kind", got.kind, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)       report_mismatch("item_kind", got.kind, want.kind);
      if (got.framing !== want.framing) report_mismatch("framing_info", got.framing,
                                                        want.framing);
      if (got.seq !== want.seq)         report_mismatch("seq_number", got.seq, want.seq);
      if (got.lval !== want.lval)       report_mismatch("length_value", got.lval, want.lval);
      if (got.lidx !== want.lidx)       report_mismatch("length_index", got.lidx, want.lidx);
      if (got.pbyte !== want.pbyte)     report_mismatch("payload_byte", got.pbyte,
                                                        want.pbyte);
      if (got.last !== want.last)       report_mismatch("header_last", got.last, want.last);
      if (got.ovf !== want.ovf)         report_mismatch("li_overflow", got.ovf, want.ovf);
      case (want.kind)
        KIND_FIXED: n_fixed++;
        KIND_LI: begin
          n_li++;
          if (want.ovf) n_ovf++;
        end
        default: n_payload++;
      endcase
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_wdata_i = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       data_byte_i = '0;
  logic             pdu_start_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [1:0]       item_kind_o;
  logic [1:0]       framing_info_o;
  logic [SEQ_W-1:0] seq_number_o;
  logic [LEN_W-1:0] length_value_o;
  logic [IDX_W-1:0] length_index_o;
  logic [7:0]       payload_byte_o;
  logic             header_last_o;
  logic             li_overflow_o;

  hdr_scoreboard sb = new();
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   hold_tokens = 0;
  int unsigned   holds_taken = 0;
  int unsigned   hold_left = 0;
  result_t       got_result;

  um_pdu_header_parser_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .pdu_start_i    (pdu_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_o    (item_kind_o),
    .framing_info_o (framing_info_o),
    .seq_number_o   (seq_number_o),
    .length_value_o (length_value_o),
    .length_index_o (length_index_o),
    .payload_byte_o (payload_byte_o),
    .header_last_o  (header_last_o),
    .li_overflow_o  (li_overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Result side: check accepted results, then choose the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_result.kind    = item_kind_e'(item_kind_o);
      got_result.framing = framing_info_o;
      got_result.seq     = seq_number_o;
      got_result.lval    = length_value_o;
      got_result.lidx    = length_index_o;
      got_result.pbyte   = payload_byte_o;
      got_result.last    = header_last_o;
      got_result.ovf     = li_overflow_o;
      sb.check_result(got_result);
    end
    if (hold_left == 0 && holds_taken != hold_tokens) begin
      holds_taken++;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    pdu_start_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b, s);
  endtask

  // Builds one PDU and sends at most cut of its bytes.
  task automatic send_pdu(input bit ten, input int n_lis, input int n_pay, input int cut);
    logic [7:0]  q[$];
    logic [10:0] cur;
    logic [10:0] nxt;
    bit          e0;
    bit          e1;
    int          i;
    if (ten) begin
      q.push_back({3'($urandom), 2'($urandom), 1'(n_lis > 0), 2'($urandom)});
      q.push_back(8'($urandom));
    end else begin
      q.push_back({2'($urandom), 1'(n_lis > 0), 5'($urandom)});
    end
    i = 0;
    while (i < n_lis) begin
      cur = 11'($urandom);
      e0 = (i + 1 < n_lis);
      q.push_back({e0, cur[10:4]});
      if (e0) begin
        // Two length indicators share three bytes.
        nxt = 11'($urandom);
        e1 = (i + 2 < n_lis);
        q.push_back({cur[3:0], e1, nxt[10:8]});
        q.push_back(nxt[7:0]);
        i += 2;
      end else begin
        q.push_back({cur[3:0], 4'($urandom)});
        i += 1;
      end
    end
    repeat (n_pay) q.push_back(8'($urandom));
    while (q.size() > cut) void'(q.pop_back());
    foreach (q[k]) send_item(q[k], k == 0);
  endtask

  task automatic write_sn_mode(input bit ten);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ten;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.ten_bit = ten;
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned goal;
    int          r;
    int          n_lis;
    int          n_pay;
    goal = sb.inputs_noted + quota;
    // One long header per phase so that the count limit is always reached.
    send_pdu(sb.ten_bit, 18, 2, 1000);
    while (sb.inputs_noted < goal) begin
      r = $urandom_range(99);
      n_lis = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
      n_pay = $urandom_range(0, 6);
      if (r < 80) begin
        send_pdu(sb.ten_bit, n_lis, n_pay, 1000);
      end else if (r < 92) begin
        send_pdu(sb.ten_bit, n_lis, n_pay, $urandom_range(1, 5));
      end else if (r < 96) begin
        send_pdu(!sb.ten_bit, n_lis, n_pay, 1000);
      end else begin
        repeat ($urandom_range(1, 4)) send_item(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("um_pdu_header_parser_top_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct  <= 26;
    recv_stall_pct <= 75;
    write_sn_mode(1'b0);

    // Short header: bytes before any start, extremes, a padded odd count and
    // a start that cuts into a header.
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h0F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hE0, 1'b1);
    send_item(8'h80, 1'b0);
    send_item(8'h1F, 1'b1);
    // The mode changes in the middle of a header and must not affect it.
    send_item(8'hA0, 1'b1);
    write_sn_mode(1'b1);
    send_item(8'h85, 1'b0);
    send_item(8'h30, 1'b0);
    send_item(8'h00, 1'b0);
    // Long header: reserved bits set, extremes, a single padded length indicator.
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h0A, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b0);

    write_sn_mode(1'b0);
    run_random(440);

    send_idle_pct  <= 75;
    recv_stall_pct <= 26;
    write_sn_mode(1'b1);
    run_random(450);

    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    write_sn_mode(1'b0);
    hold_tokens <= hold_tokens + 1;
    run_random(450);

    write_sn_mode(1'b1);
    run_random(450);

    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_PAD) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      sb.report_mismatch("results still pending at the end", sb.expected_q.size(), 0);
    end
    $display("um_pdu_header_parser_top_tb: %0d bytes in, %0d fixed headers, %0d LIs",
             sb.inputs_noted, sb.n_fixed, sb.n_li);
    $display("um_pdu_header_parser_top_tb: %0d LIs past the limit, %0d payload bytes",
             sb.n_ovf, sb.n_payload);
    if (sb.errors == 0) begin
      $display("um_pdu_header_parser_top_tb: done, clean");
    end else begin
      $display("um_pdu_header_parser_top_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/um_hdr_pkg.sv
design/um_hdr_in_reg.sv
design/um_hdr_core.sv
design/um_hdr_out_reg.sv
design/um_pdu_header_parser_top.sv
verif/um_pdu_header_parser_top_tb.sv
